@@ design/multi_click_key_classifier_unit_defines.svh @@
`ifndef MULTI_CLICK_KEY_CLASSIFIER_UNIT_DEFINES_SVH
`define MULTI_CLICK_KEY_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mcc_pkg.sv @@
`timescale 1ns / 1ps

package mcc_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ROUNDS     = 1'b1;

    localparam logic [4:0] RELEASE_TIMEOUT_RST = 5'd8;
    localparam logic [3:0] LONG_ROUNDS_RST     = 4'd3;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_TRIPLE = 3'd3,
        EV_LONG   = 3'd4
    } event_t;

    typedef struct packed {
        logic [4:0] release_timeout;
        logic [3:0] long_rounds;
    } cfg_t;

    typedef struct packed {
        event_t event_code;
        logic   busy;
    } result_t;

    typedef struct packed {
        logic   none;
        event_t code;
    } count_t;

    // swar popcount over a 32-bit word
    function automatic logic [5:0] popcount32(input logic [31:0] w);
        logic [31:0] m;
        m = (w & 32'h5555_5555) + ((w >> 1) & 32'h5555_5555);
        m = (m & 32'h3333_3333) + ((m >> 2) & 32'h3333_3333);
        m = (m + (m >> 4)) & 32'h0F0F_0F0F;
        m = m + (m >> 8);
        m = m + (m >> 16);
        return m[5:0];
    endfunction

endpackage

@@ design/mcc_sample_if.sv @@
`timescale 1ns / 1ps

interface mcc_sample_if;
    logic valid;
    logic ready;
    logic level_released;

    modport source (output valid, output level_released, input ready);
    modport sink (input valid, input level_released, output ready);
endinterface

@@ design/mcc_result_if.sv @@
`timescale 1ns / 1ps

interface mcc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       busy_res;

    modport source (output valid, output event_code, output busy_res, input ready);
    modport sink (input valid, input event_code, input busy_res, output ready);
endinterface

@@ design/multi_click_key_classifier_unit.sv @@
// multi-click key classifier
// sample channel: one key level per beat, 1 released, 0 pressed.
// result channel: one beat per sample beat, in order: event_code
//   (0 none, 1 single, 2 double, 3 triple, 4 long press) and busy_res,
//   high while a sampling window stays open after that sample.
// config port: cfg_we with cfg_index 0 writes release_timeout (5 bits),
//   index 1 writes long_rounds (low 4 bits of cfg_data); write only while idle.
// result register: a result beat appears in the cycle after its sample beat is taken.
// throughput: one sample per cycle unless a pending result is stalled;
//   the key state update, the transition popcount and the classification
//   all settle combinationally between the state and result registers.
// receiver stall: the result register holds its beat and the sample side
//   keeps taking beats only when that register drains in the same cycle.
// reset: all key state clears, no result is pending, release_timeout
//   returns to 8 and long_rounds to 3.
`timescale 1ns / 1ps
`include "multi_click_key_classifier_unit_defines.svh"

module multi_click_key_classifier_unit
    import mcc_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mcc_sample_if.sink            sample,
    mcc_result_if.source          result
);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    event_t  ev_reg;
    logic    busy_reg;
    logic    step;
    result_t res;

    assign sample.ready = !out_valid_reg || result.ready;
    assign step = sample.valid && sample.ready;

    mcc_window #(.WINDOW(WINDOW)) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .lvl   (sample.level_released),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_timeout <= RELEASE_TIMEOUT_RST;
            cfg_reg.long_rounds     <= LONG_ROUNDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RELEASE_TIMEOUT: cfg_reg.release_timeout <= cfg_data[4:0];
                CFG_LONG_ROUNDS:     cfg_reg.long_rounds <= cfg_data[3:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            out_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            ev_reg   <= res.event_code;
            busy_reg <= res.busy;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.event_code = ev_reg;
    assign result.busy_res   = busy_reg;

    // a reported click or long press always closes the window
    `MCC_ASSERT_NOW(a_event_closes, out_valid_reg && ev_reg != EV_NONE, !busy_reg,
        "event reported with window still open")
    `MCC_ASSERT_NEXT(a_beat_follows, step, out_valid_reg,
        "accepted sample produced no result beat")
    `MCC_ASSERT_NEXT(a_drain_empty, out_valid_reg && result.ready && !step, !out_valid_reg,
        "result beat repeated after drain")

endmodule

@@ design/mcc_count.sv @@
`timescale 1ns / 1ps

module mcc_count
    import mcc_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  logic [WINDOW-1:0] bits,
    output count_t            cnt
);

    logic [WINDOW-1:0] marks;
    logic [31:0]       marks_ext;
    logic [5:0]        n;

    // a press sample directly older than a released one
    assign marks = ~bits & {bits[WINDOW-2:0], 1'b0};

    always_comb
    begin
        marks_ext = '0;
        marks_ext[WINDOW-1:0] = marks;
        n = popcount32(marks_ext);
        cnt.none = (n == 6'd0);
        if (n != 6'd0 && n <= 6'd3)
        begin
            cnt.code = event_t'(n[2:0]);
        end
        else
        begin
            cnt.code = EV_NONE;
        end
    end

endmodule

@@ design/mcc_window.sv @@
`timescale 1ns / 1ps

module mcc_window
    import mcc_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    lvl,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SH_W  = $clog2(WINDOW);

    logic              prev_reg, prev_next;
    logic              cur_reg, cur_next;
    logic              open_reg, open_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WINDOW-1:0] bits_reg, bits_next;
    logic [4:0]        run_reg, run_next;
    logic [3:0]        quiet_reg, quiet_next;

    count_t            tally;
    logic              go;
    logic [WINDOW-1:0] shifted;
    logic [4:0]        run_inc;
    logic [3:0]        quiet_base;
    logic [3:0]        quiet_inc;
    logic [SH_W-1:0]   sh;
    event_t            ev;

    mcc_count #(.WINDOW(WINDOW)) u_count (
        .bits (bits_reg),
        .cnt  (tally)
    );

    always_comb
    begin
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        open_next  = open_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        run_next   = run_reg;
        quiet_next = quiet_reg;
        ev         = EV_NONE;
        go         = 1'b1;
        quiet_base = quiet_reg;

        shifted = {bits_reg[WINDOW-2:0], lvl};
        run_inc = (run_reg == 5'd31) ? run_reg : run_reg + 5'd1;
        sh      = SH_W'(WINDOW - 1) - cnt_reg[SH_W-1:0];

        if (!open_reg)
        begin
            prev_next = cur_reg;
            cur_next  = lvl;
            if (!(lvl == 1'b0 && cur_reg == 1'b1))
            begin
                cnt_next = '0;
                bits_next = '0;
                run_next = '0;
                go = 1'b0;
            end
            else
            begin
                quiet_next = '0;
                quiet_base = '0;
            end
        end

        quiet_inc = (quiet_base == 4'd15) ? quiet_base : quiet_base + 4'd1;

        if (go)
        begin
            if (cnt_reg < CNT_W'(WINDOW))
            begin
                open_next = 1'b1;
                if (lvl)
                begin
                    if (run_inc >= cfg.release_timeout)
                    begin
                        // early close: pad the untaken positions with released
                        run_next  = '0;
                        bits_next = (shifted << sh) | ~({WINDOW{1'b1}} << sh);
                        cnt_next  = CNT_W'(WINDOW);
                    end
                    else
                    begin
                        run_next  = run_inc;
                        bits_next = shifted;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    run_next  = '0;
                    bits_next = shifted;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                open_next = 1'b0;
                cnt_next  = '0;
                if (tally.none)
                begin
                    quiet_next = quiet_inc;
                    if (quiet_inc >= cfg.long_rounds)
                    begin
                        ev = EV_LONG;
                    end
                    else
                    begin
                        open_next = 1'b1;
                    end
                end
                else
                begin
                    ev = tally.code;
                end
            end
        end

        res.event_code = ev;
        res.busy       = open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            cur_reg   <= 1'b0;
            open_reg  <= 1'b0;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            run_reg   <= '0;
            quiet_reg <= '0;
        end
        else if (step)
        begin
            prev_reg  <= prev_next;
            cur_reg   <= cur_next;
            open_reg  <= open_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            run_reg   <= run_next;
            quiet_reg <= quiet_next;
        end
    end

endmodule

@@ sim/multi_click_key_classifier_unit_test.sv @@
`timescale 1ns / 1ps

module multi_click_key_classifier_unit_test;
    import mcc_pkg::*;

    localparam int WINDOW_LEN  = 32;
    localparam int PHASE_ITEMS = 210;
    localparam int LONG_HOLD   = 64;
    localparam int CYCLE_LIMIT = 500000;

    class click_scoreboard;
        logic [4:0]  release_timeout;
        logic [3:0]  long_rounds;
        logic        prev_level;
        logic        cur_level;
        logic        window_open;
        logic [5:0]  sample_count;
        logic [31:0] window_bits;
        logic [4:0]  release_run;
        logic [3:0]  quiet_rounds;
        result_t     expected_events[$];
        int          error_count;

        function new();
            release_timeout = RELEASE_TIMEOUT_RST;
            long_rounds     = LONG_ROUNDS_RST;
            prev_level      = 1'b0;
            cur_level       = 1'b0;
            window_open     = 1'b0;
            sample_count    = '0;
            window_bits     = '0;
            release_run     = '0;
            quiet_rounds    = '0;
            error_count     = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_RELEASE_TIMEOUT)
                release_timeout = data[4:0];
            else if (idx == CFG_LONG_ROUNDS)
                long_rounds = data[3:0];
        endfunction

        function int pending_count();
            return expected_events.size();
        endfunction

        // work out the result beat caused by one accepted key sample
        function void note_level(logic lvl);
            result_t     r;
            logic [5:0]  shift;
            logic [63:0] wide;
            logic [31:0] rising;
            int          transitions;
            r.event_code = EV_NONE;
            r.busy       = 1'b0;
            if (!window_open) begin
                prev_level = cur_level;
                cur_level  = lvl;
                if (!(cur_level == 1'b0 && prev_level == 1'b1)) begin
                    sample_count = '0;
                    window_bits  = '0;
                    release_run  = '0;
                    expected_events.push_back(r);
                    return;
                end
                quiet_rounds = '0;
            end
            if (sample_count < WINDOW_LEN) begin
                window_open = 1'b1;
                window_bits = window_bits << 1;
                if (lvl) begin
                    window_bits[0] = 1'b1;
                    if (release_run < 5'd31)
                        release_run = release_run + 5'd1;
                    if (release_run >= release_timeout) begin
                        // early close: pad the rest of the window with released
                        shift        = 6'(WINDOW_LEN - 1) - sample_count;
                        release_run  = '0;
                        wide         = ({32'b0, window_bits} << shift) | ((64'd1 << shift) - 64'd1);
                        window_bits  = wide[31:0];
                        sample_count = 6'(WINDOW_LEN - 1);
                    end
                end
                else begin
                    release_run = '0;
                end
                sample_count = sample_count + 6'd1;
            end
            else begin
                // a press-to-release transition is a 0 with a 1 just newer
                rising       = ~window_bits & (window_bits << 1);
                transitions  = $countones(rising);
                window_open  = 1'b0;
                sample_count = '0;
                if (transitions == 0) begin
                    if (quiet_rounds < 4'd15)
                        quiet_rounds = quiet_rounds + 4'd1;
                    if (quiet_rounds >= long_rounds)
                        r.event_code = EV_LONG;
                    else
                        window_open = 1'b1;
                end
                else begin
                    case (transitions)
                        1: r.event_code = EV_SINGLE;
                        2: r.event_code = EV_DOUBLE;
                        3: r.event_code = EV_TRIPLE;
                        default: r.event_code = EV_NONE;
                    endcase
                end
            end
            r.busy = window_open;
            expected_events.push_back(r);
        endfunction

        function void check_event(logic [2:0] code, logic busy);
            result_t want;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result beat, actual event_code=%0d busy_res=%0b",
                         $time, code, busy);
                error_count++;
                return;
            end
            want = expected_events.pop_front();
            if (code !== want.event_code) begin
                $display("%0t: event_code mismatch, expected %0d, actual %0d",
                         $time, want.event_code, code);
                error_count++;
            end
            if (busy !== want.busy) begin
                $display("%0t: busy_res mismatch, expected %0b, actual %0b",
                         $time, want.busy, busy);
                error_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcc_sample_if sample_ch ();
    mcc_result_if result_ch ();

    click_scoreboard sb;

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int cur_rt;
    int cur_lr;
    int hold_requests;
    int hold_served;
    int hold_left;
    int cycle_count;

    multi_click_key_classifier_unit #(
        .WINDOW(WINDOW_LEN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #6 clk = ~clk;

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served     <= hold_served + 1;
            hold_left       <= LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_event(result_ch.event_code, result_ch.busy_res);
            if (sample_ch.valid && sample_ch.ready)
                sb.note_level(sample_ch.level_released);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_click_key_classifier_unit_test NOT OK");
            $finish;
        end
    end

    task automatic send_level(input logic lvl);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.level_released <= lvl;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        items_sent++;
    endtask

    task automatic play_pattern(input string bits);
        for (int i = 0; i < bits.len(); i++)
            send_level(bits[i] == "1");
    endtask

    // both registers back to back, block idle
    task automatic write_settings(input int rt, input logic [CFG_DATA_W-1:0] lr_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RELEASE_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(rt);
        @(posedge clk);
        sb.set_config(CFG_RELEASE_TIMEOUT, CFG_DATA_W'(rt));
        cfg_index <= CFG_LONG_ROUNDS;
        cfg_data  <= lr_data;
        @(posedge clk);
        sb.set_config(CFG_LONG_ROUNDS, lr_data);
        cfg_we <= 1'b0;
        cur_rt = rt;
        cur_lr = lr_data[3:0];
    endtask

    // the first edge lets the last accepted beat reach the scoreboard
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic play_gesture();
        int kind;
        int clicks;
        int hold_len;
        int rel_max;
        kind = $urandom_range(0, 15);
        if (kind == 0)
        begin
            // hold the key for a random run of up to (cur_lr + 1) * (WINDOW_LEN + 1) + 4 samples
            send_level(1'b1);
            hold_len = $urandom_range(1, (cur_lr + 1) * (WINDOW_LEN + 1) + 4);
            repeat (hold_len) send_level(1'b0);
            repeat (cur_rt + 2) send_level(1'b1);
        end
        else if (kind <= 3)
        begin
            repeat ($urandom_range(3, 24)) send_level(1'($urandom_range(0, 1)));
        end
        else
        begin
            rel_max = (cur_rt > 1) ? ((cur_rt - 1 < 8) ? cur_rt - 1 : 8) : 1;
            repeat ($urandom_range(1, 3)) send_level(1'b1);
            clicks = $urandom_range(1, 5);
            repeat (clicks)
            begin
                repeat ($urandom_range(1, 4)) send_level(1'b0);
                repeat ($urandom_range(1, rel_max)) send_level(1'b1);
            end
            repeat (cur_rt + $urandom_range(1, 3)) send_level(1'b1);
        end
    endtask

    initial
    begin
        int rt_tab[8];
        int lr_tab[8];
        int phase_start;
        bit hold_done;
        rt_tab = '{8, 1, 31, 0, 4, 31, 1, 0};
        lr_tab = '{3, 1, 15, 0, 2, 1, 15, 0};
        rt_tab[7] = $urandom_range(0, 31);
        lr_tab[7] = $urandom_range(0, 15);

        clk                      = 1'b0;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CFG_RELEASE_TIMEOUT;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.level_released = 1'b1;
        result_ch.ready          = 1'b0;
        tx_idle_pct              = 0;
        rx_idle_pct              = 0;
        items_sent               = 0;
        hold_requests            = 0;
        hold_served              = 0;
        hold_left                = 0;
        cycle_count              = 0;
        cur_rt                   = RELEASE_TIMEOUT_RST;
        cur_lr                   = LONG_ROUNDS_RST;
        sb = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short timeout so single, double and triple fit in a few samples
        write_settings(2, 5'd1);
        play_pattern("10111");
        play_pattern("1010111");
        play_pattern("101010111");
        sample_ch.valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 56; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 56; end
                default: begin tx_idle_pct = 27; rx_idle_pct = 27; end
            endcase
            write_settings(rt_tab[phase], {1'($urandom_range(0, 1)), 4'(lr_tab[phase])});
            phase_start = items_sent;
            hold_done   = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // stall the result side while samples keep coming
                if ((phase == 0 || phase == 5) && !hold_done &&
                    items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    hold_requests <= hold_requests + 1;
                    hold_done = 1'b1;
                end
                play_gesture();
            end
            sample_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (sb.error_count == 0)
            $display("multi_click_key_classifier_unit_test OK");
        else
            $display("multi_click_key_classifier_unit_test NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/mcc_pkg.sv
design/mcc_sample_if.sv
design/mcc_result_if.sv
design/mcc_count.sv
design/mcc_window.sv
design/multi_click_key_classifier_unit.sv
sim/multi_click_key_classifier_unit_test.sv
